/* rtl/moving_average_filter_assert.svh */
// ----------------------------------------------------------------------------
// moving_average_filter assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

`ifndef SYNTH
// holds at every edge outside reset
`define MAF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MAF_ASSERT(lbl, clk, rst_n, prop)
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/maf_pkg.sv */
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and constants of the moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

  localparam int CFG_LEN_BITS = 7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

/* rtl/maf_ram.sv */
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/maf_div.sv */
// ----------------------------------------------------------------------------
// maf_div
// Bit-serial restoring divider: one quotient bit per cycle, dividend shifted
// out of a shift register MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_average_filter_assert.svh"

module maf_div
  import maf_pkg::*;
#(
  parameter int N_BITS = 22,
  parameter int D_BITS = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [N_BITS-1:0] dividend,
  input  wire logic [D_BITS-1:0] divisor,
  output div_status_t            status,
  output logic      [N_BITS-1:0] quotient
);

  localparam int CW = $clog2(N_BITS + 1);

  logic [D_BITS-1:0] rem_r, rem_nxt;
  logic [N_BITS-1:0] quo_r, quo_nxt;
  logic [D_BITS-1:0] div_r, div_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [D_BITS:0]   trial;
  logic [D_BITS:0]   diff;

  assign trial = {rem_r, quo_r[N_BITS-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
      cnt_nxt  = CW'(N_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[D_BITS-1:0];
        quo_nxt = {quo_r[N_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[D_BITS-1:0];
        quo_nxt = {quo_r[N_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

  `MAF_ASSERT(a_busy_cnt, clk, rst_n, !busy_r || (cnt_r != '0))
  `MAF_ASSERT(a_done_idle, clk, rst_n, !done_r || !busy_r)
  `MAF_ASSERT(a_rem_bound, clk, rst_n, !busy_r || start || (rem_r < div_r))

endmodule

`default_nettype wire

/* rtl/moving_average_filter.sv */
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average: running sum over a sample ring, serial divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_sample carries one signed sample per
//   transfer; output channel out_valid/out_ready/out_average returns one
//   average per sample, in order. cfg_we/cfg_wdata sets the window length
//   (0 reads as 1, values above MAX_WINDOW saturate) and restarts the filter
//   from an empty window; write it only while the block is idle.
//   Flow: the leaving sample is read from the ring RAM as the sample is
//   accepted; ST_SUM updates the running sum and starts the bit-serial
//   divider over SUM_BITS quotient bits (SUM_BITS = SAMPLE_BITS +
//   clog2(MAX_WINDOW)); ST_DIV then registers the result and ST_OUT hands
//   it to the output register, after which the next sample can be taken.
//   Reset: window length 8, empty window (missing samples count as zero);
//   the ring is tracked by a fill count, so there is no clearing pass.
//   Stall: the result sits in the output register until transferred; a new
//   sample is taken meanwhile, but its result waits for the register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "moving_average_filter_assert.svh"

module moving_average_filter
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_BITS-1:0]  in_sample,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [SAMPLE_BITS-1:0]  out_average,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_LEN_BITS-1:0] cfg_wdata
);

  localparam int AW         = $clog2(MAX_WINDOW);
  localparam int LEN_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS   = SAMPLE_BITS + AW;
  localparam int RESET_LEN  = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [LEN_BITS-1:0]      len_r, len_nxt;
  logic [LEN_BITS-1:0]      fill_r, fill_nxt;
  logic [AW-1:0]            wp_r, wp_nxt;
  logic [SUM_BITS-1:0]      sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0]   sample_r, sample_nxt;
  logic                     neg_r, neg_nxt;
  logic [SAMPLE_BITS-1:0]   result_r, result_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0]   out_average_r, out_average_nxt;

  logic                     accept;
  logic [31:0]              cfg_ext;
  logic [LEN_BITS-1:0]      cfg_len;
  logic [LEN_BITS-1:0]      wp_ext;
  logic [AW-1:0]            oldest;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic [SAMPLE_BITS-1:0]   old_sample;
  logic [SUM_BITS-1:0]      new_sum;
  logic [SUM_BITS-1:0]      sum_mag;
  logic                     div_start;
  div_status_t              div_st;
  logic [SUM_BITS-1:0]      quotient;
  logic [SUM_BITS-1:0]      quo_signed;

  assign accept = in_valid && in_ready;

  assign cfg_ext = 32'(cfg_wdata);
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_len = LEN_BITS'(1);
    end else if (cfg_ext > 32'(MAX_WINDOW)) begin
      cfg_len = LEN_BITS'(MAX_WINDOW);
    end else begin
      cfg_len = LEN_BITS'(cfg_ext);
    end
  end

  // ring slot of the sample leaving the window
  assign wp_ext = LEN_BITS'(wp_r);
  always_comb begin
    if (wp_ext >= len_r) begin
      oldest = AW'(wp_ext - len_r);
    end else begin
      oldest = AW'(wp_ext + LEN_BITS'(MAX_WINDOW) - len_r);
    end
  end

  // slot never written since the last clear reads as zero
  assign old_sample = (fill_r >= len_r) ? ram_rdata : '0;
  assign new_sum = sum_r
                 + {{AW{sample_r[SAMPLE_BITS-1]}}, sample_r}
                 - {{AW{old_sample[SAMPLE_BITS-1]}}, old_sample};
  assign sum_mag    = new_sum[SUM_BITS-1] ? (SUM_BITS'(0) - new_sum) : new_sum;
  assign div_start  = (state_r == ST_SUM);
  assign quo_signed = neg_r ? (SUM_BITS'(0) - quotient) : quotient;

  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == ST_SUM),
    .waddr (wp_r),
    .wdata (sample_r),
    .re    (accept),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  maf_div #(
    .N_BITS (SUM_BITS),
    .D_BITS (LEN_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag),
    .divisor  (len_r),
    .status   (div_st),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt       = state_r;
    len_nxt         = len_r;
    fill_nxt        = fill_r;
    wp_nxt          = wp_r;
    sum_nxt         = sum_r;
    sample_nxt      = sample_r;
    neg_nxt         = neg_r;
    result_nxt      = result_r;
    out_valid_nxt   = out_valid_r;
    out_average_nxt = out_average_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sample_nxt = in_sample;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt = new_sum;
        neg_nxt = new_sum[SUM_BITS-1];
        if (wp_ext == LEN_BITS'(MAX_WINDOW - 1)) begin
          wp_nxt = '0;
        end else begin
          wp_nxt = wp_r + AW'(1);
        end
        if (fill_r != LEN_BITS'(MAX_WINDOW)) begin
          fill_nxt = fill_r + LEN_BITS'(1);
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          result_nxt = quo_signed[SAMPLE_BITS-1:0];
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = result_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      len_nxt  = cfg_len;
      fill_nxt = '0;
      wp_nxt   = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_BITS'(RESET_LEN);
      fill_r      <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r      <= sample_nxt;
    neg_r         <= neg_nxt;
    result_r      <= result_nxt;
    out_average_r <= out_average_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  `MAF_ASSERT(a_len_range, clk, rst_n, (len_r != '0) && (len_r <= LEN_BITS'(MAX_WINDOW)))
  `MAF_ASSERT(a_fill_range, clk, rst_n, fill_r <= LEN_BITS'(MAX_WINDOW))
  `MAF_ASSERT(a_div_done_state, clk, rst_n, !div_st.done || (state_r == ST_DIV))
  `MAF_ASSERT_NEXT(a_sum_to_div, clk, rst_n, state_r == ST_SUM, div_st.busy)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Moving average filter testbench. Drives signed samples over the input
// handshake, changes the window length between phases, and checks every
// average against a running-sum predictor with truncating division. Both
// channels idle in random bursts, except during a final steady stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import maf_pkg::*;

  localparam int WIN_MAX  = 64;
  localparam int SAMPLE_W = 16;
  localparam int LATENCY  = 30;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_W-1:0]     in_sample  = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [SAMPLE_W-1:0]     out_average;
  logic                    cfg_we     = 1'b0;
  logic [CFG_LEN_BITS-1:0] cfg_wdata  = '0;

  // predictor state
  logic signed [SAMPLE_W-1:0] hist_ring [WIN_MAX];
  int                         hist_ptr;
  int                         hist_sum;
  int                         win_len;

  logic [SAMPLE_W-1:0] pending_averages [$];
  int                  mismatches  = 0;
  int                  stall_left  = 0;
  bit                  steady      = 1'b0;

  moving_average_filter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_history();
    for (int i = 0; i < WIN_MAX; i++) hist_ring[i] = '0;
    hist_ptr = 0;
    hist_sum = 0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] predict_average(logic signed [SAMPLE_W-1:0] x);
    int oldest;
    int quot;
    oldest   = (hist_ptr + WIN_MAX - win_len) % WIN_MAX;
    hist_sum = hist_sum + x - hist_ring[oldest];
    hist_ring[hist_ptr] = x;
    hist_ptr = (hist_ptr + 1) % WIN_MAX;
    quot     = hist_sum / win_len;
    return quot[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int style);
    case (style)
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return SAMPLE_W'($urandom_range(0, 16) - 8);
      default: begin
        case ($urandom_range(0, 9))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return SAMPLE_W'($urandom_range(0, 6) - 3);
          default: return SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_averages.size() == 0) begin
        $display("%0t: unexpected average: expected none, actual %0d", $time,
                 $signed(out_average));
        mismatches++;
      end else begin
        logic [SAMPLE_W-1:0] want;
        want = pending_averages.pop_front();
        if (want !== out_average) begin
          $display("%0t: average mismatch: expected %0d, actual %0d", $time,
                   $signed(want), $signed(out_average));
          mismatches++;
        end
      end
    end
  end

  // output stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!steady && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    if (!steady && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_averages = {pending_averages, predict_average(x)};
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_LEN_BITS-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (value == 0) win_len = 1;
    else if (value > WIN_MAX) win_len = WIN_MAX;
    else win_len = value;
    clear_history();
  endtask

  // default window of 8, zeros fill the start
  task automatic test_startup_default();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h5555);
  endtask

  // zero reads as one, oversize saturates
  task automatic test_window_limits();
    write_window(7'd0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hAAAA);
    write_window(7'd127);
    send_sample(16'h8000);
    send_sample(16'h8000);
    write_window(7'd65);
    send_sample(16'h7FFF);
    send_sample(16'h1234);
    write_window(7'd64);
    send_sample(16'h8001);
    write_window(7'd1);
    send_sample(16'hFFFF);
    send_sample(16'h7FFE);
  endtask

  // negative sums truncate toward zero
  task automatic test_truncation();
    write_window(7'd3);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'h0005);
  endtask

  task automatic test_random_traffic();
    int style;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_window(7'd64); style = 1; end
        1: begin write_window(7'd64); style = 2; end
        2: begin write_window(7'd2);  style = 0; end
        3: begin write_window(7'd0);  style = 0; end
        default: begin
          write_window(CFG_LEN_BITS'($urandom_range(0, 127)));
          style = $urandom_range(0, 3);
        end
      endcase
      for (int i = 0; i < 100; i++) begin
        if (style != 0 && $urandom_range(0, 19) == 0) send_sample(pick_sample(0));
        else send_sample(pick_sample(style));
      end
    end
  endtask

  task automatic test_steady_stream();
    write_window(CFG_LEN_BITS'($urandom_range(1, 64)));
    steady = 1'b1;
    for (int i = 0; i < 100; i++) send_sample(pick_sample(0));
  endtask

  initial begin
    win_len = 8;
    clear_history();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_startup_default();
    test_window_limits();
    test_truncation();
    test_random_traffic();
    test_steady_stream();

    drain_results();
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* moving_average_filter.f */
+incdir+rtl
rtl/maf_pkg.sv
rtl/maf_ram.sv
rtl/maf_div.sv
rtl/moving_average_filter.sv
tb/tb_top.sv
